FILE: hdl/psba_pkg.sv
// Package with the shared constants and codes of the page slot bitmap allocator.
`default_nettype none

package psba_pkg;

	localparam int PAGE_BYTES = 4096;
	localparam int MAX_SLOTS  = 4096;

	localparam int BITS_PER_BYTE = 8;
	localparam int PAGE_BITS     = PAGE_BYTES * BITS_PER_BYTE;

	// Field widths fixed by the interface.
	localparam int TSZ_W    = 12;
	localparam int SLOT_W   = 12;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int RSLOT_W  = 13;
	localparam int OFS_W    = 12;

	// Bitmap memory geometry: 64 slots per word.
	localparam int WORD_W  = 64;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int WORDS   = MAX_SLOTS / WORD_W;
	localparam int IDX_W   = $clog2(MAX_SLOTS);
	localparam int WADDR_W = IDX_W - BIT_W;
	localparam int CAP_W   = $clog2(MAX_SLOTS + 1);

	// Capacity divider: numerator is the page size in bits.
	localparam int NUM_W  = $clog2(PAGE_BITS + 1);
	localparam int DEN_W  = TSZ_W + 3;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	// Reset configuration.
	localparam int TSZ_RST = 8;
	localparam int CAP_RAW = PAGE_BITS / (TSZ_RST * BITS_PER_BYTE + 1);
	localparam int CAP_RST = (CAP_RAW > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW;
	localparam int BASE_RST = PAGE_BYTES - CAP_RST * TSZ_RST;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_BASE,
		S_SCAN,
		S_MUL,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/psba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module psba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/page_slot_bitmap_allocator.sv
// Top level of the page slot bitmap allocator: command sequencer around the bitmap memory.
//
// Usage: commands arrive on the s_ stream (s_tuser carries the command code,
// s_tdata the slot index) and each one produces exactly one result transfer on
// the m_ stream (m_tuser carries the status, m_tdata the slot, the occupied flag
// and the byte offset). The tuple size is written through the cfg_ channel
// while no command is in flight.
// The occupancy bitmap lives in a 64-word by 64-bit memory with a registered
// read. Insert, first and next read one word per cycle and stop at the first
// word with a hit or at the last word in capacity, visiting at most 64 words
// for a 4096-slot page. Delete and query visit one word; out-of-range and
// reserved commands skip the memory.
// A tuple size write starts a restoring divider for the slot capacity, then a
// step that sets the offset base; commands wait meanwhile.
// Reset clears the per-word valid bits, so the page reads as empty at once
// without a clearing pass, and loads a tuple size of 8 with 504 slots.
// A result waits in the output register while the receiver stalls; the next
// command is still accepted, and the sequencer holds its finished result
// until the output register frees up.
`default_nettype none

module page_slot_bitmap_allocator
	import psba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write: tuple size in bytes.
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [TSZ_W-1:0]  cfg_data,
	// Command stream.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,   // [11:0] slot
	input  wire logic [7:0]        s_tuser,   // [2:0] cmd
	// Result stream.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [31:0]       m_tdata,   // [12:0] result_slot, [13] occupied,
	                                          // [25:14] byte_offset
	output logic      [7:0]        m_tuser    // [1:0] status
);

	state_t state_q, state_d;

	// Configuration and derived page geometry.
	logic [TSZ_W-1:0]  sz_q;
	logic [CAP_W-1:0]  cap_q;
	logic [OFS_W-1:0]  base_q;

	// Capacity divider.
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DEN_W:0]    rem_sh;
	logic              rem_ge;
	logic [TSZ_W-1:0]  cfg_sz;
	logic [CAP_W-1:0]  cap_sat;
	logic [CAP_W+TSZ_W-1:0] cap_prod;

	// Command registers.
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [IDX_W-1:0]  from_q;
	logic [WADDR_W-1:0] word_q;
	logic              vld_s1;
	logic [WADDR_W-1:0] word_s1;

	// Result registers.
	logic [STATUS_W-1:0] res_status_q;
	logic [RSLOT_W-1:0]  res_slot_q;
	logic                res_occ_q;
	logic                res_want_q;
	logic [OFS_W-1:0]    prod_q;
	logic [2*TSZ_W-1:0]  slot_prod;
	logic [OFS_W-1:0]    res_ofs;

	// Output register.
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;
	logic [7:0]          m_tuser_q;
	logic                out_free;

	// Input decode.
	logic [CMD_W-1:0]  in_cmd;
	logic [SLOT_W-1:0] in_slot;
	logic [CAP_W-1:0]  in_next;
	logic              in_range;
	logic              in_next_ok;
	logic              in_imm;
	logic              in_acc;
	logic              cfg_acc;

	// Bitmap memory and scan evaluation.
	logic [WORDS-1:0]   row_vld_q;
	logic               mem_we;
	logic [WADDR_W-1:0] mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [WORD_W-1:0]  mem_rdata;
	logic [WORD_W-1:0]  word_data;
	logic [CAP_W-1:0]   cap_m1;
	logic [WADDR_W-1:0] last_word;
	logic [WORD_W-1:0]  lo_mask;
	logic [WORD_W-1:0]  hi_mask;
	logic [WORD_W-1:0]  cand;
	logic [WORD_W-1:0]  cand_oh;
	logic [BIT_W-1:0]   cand_bit;
	logic               hit;
	logic               slot_bit;
	logic               scan_cmd;
	logic               eval_done;
	logic [WORD_W-1:0]  slot_oh;

	function automatic logic [BIT_W-1:0] encode_oh(input logic [WORD_W-1:0] oh);
		logic [BIT_W-1:0] enc;
		enc = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (oh[i]) begin
				enc = enc | BIT_W'(i);
			end
		end
		return enc;
	endfunction

	psba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(word_q),
		.rdata(mem_rdata)
	);

	// ---------------------------------------------------------------------
	// Input decode. Commands that need no bitmap access resolve right away.
	// ---------------------------------------------------------------------
	assign in_cmd     = s_tuser[CMD_W-1:0];
	assign in_slot    = s_tdata[SLOT_W-1:0];
	assign in_next    = CAP_W'(in_slot) + CAP_W'(1);
	assign in_range   = CAP_W'(in_slot) < cap_q;
	assign in_next_ok = in_next < cap_q;
	assign in_imm     = ((in_cmd == CMD_DELETE || in_cmd == CMD_QUERY) && !in_range)
	                 || (in_cmd == CMD_NEXT && !in_next_ok)
	                 || !(in_cmd == CMD_INSERT || in_cmd == CMD_DELETE
	                      || in_cmd == CMD_QUERY || in_cmd == CMD_FIRST
	                      || in_cmd == CMD_NEXT);
	assign in_acc     = s_tvalid && s_tready;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign cfg_sz     = (cfg_data == '0) ? TSZ_W'(1) : cfg_data;

	// ---------------------------------------------------------------------
	// Divider step and capacity saturation.
	// ---------------------------------------------------------------------
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign cap_sat  = (32'(num_q) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : CAP_W'(num_q);
	assign cap_prod = cap_sat * sz_q;

	// ---------------------------------------------------------------------
	// Scan evaluation of the word that the memory returns.
	// ---------------------------------------------------------------------
	assign cap_m1    = cap_q - CAP_W'(1);
	assign last_word = cap_m1[IDX_W-1:BIT_W];
	assign word_data = row_vld_q[word_s1] ? mem_rdata : '0;
	assign lo_mask   = (word_s1 == from_q[IDX_W-1:BIT_W]) ? ({WORD_W{1'b1}} << from_q[BIT_W-1:0])
	                                                       : {WORD_W{1'b1}};
	assign hi_mask   = (word_s1 == last_word)
	                 ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - cap_m1[BIT_W-1:0]))
	                 : {WORD_W{1'b1}};
	assign cand      = ((cmd_q == CMD_INSERT) ? ~word_data : word_data) & lo_mask & hi_mask;
	assign cand_oh   = cand & (~cand + WORD_W'(1));
	assign cand_bit  = encode_oh(cand_oh);
	assign hit       = |cand;
	assign slot_oh   = WORD_W'(1) << slot_q[BIT_W-1:0];
	assign slot_bit  = word_data[slot_q[BIT_W-1:0]];
	assign scan_cmd  = (cmd_q == CMD_INSERT) || (cmd_q == CMD_FIRST) || (cmd_q == CMD_NEXT);
	assign eval_done = vld_s1 && (!scan_cmd || hit || word_s1 == last_word);

	assign slot_prod = res_slot_q[SLOT_W-1:0] * sz_q;
	assign res_ofs   = res_want_q ? (base_q + prod_q) : '0;
	assign out_free  = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------------
	// Next-state logic.
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					state_d = S_DIV;
				end else if (s_tvalid) begin
					state_d = in_imm ? S_MUL : S_SCAN;
				end
			end
			S_DIV: begin
				if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
					state_d = S_BASE;
				end
			end
			S_BASE: state_d = S_IDLE;
			S_SCAN: begin
				if (eval_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Control outputs.
	// ---------------------------------------------------------------------
	always_comb begin
		cfg_ready = 1'b0;
		s_tready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = word_s1;
		mem_wdata = word_data;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
			end
			S_SCAN: begin
				mem_re = 1'b1;
				if (vld_s1) begin
					// Insert claims the lowest free bit; delete clears a set bit.
					if (cmd_q == CMD_INSERT && hit) begin
						mem_we    = 1'b1;
						mem_wdata = word_data | cand_oh;
					end else if (cmd_q == CMD_DELETE && slot_bit) begin
						mem_we    = 1'b1;
						mem_wdata = word_data & ~slot_oh;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sz_q       <= TSZ_W'(TSZ_RST);
			cap_q      <= CAP_W'(CAP_RST);
			base_q     <= OFS_W'(BASE_RST);
			row_vld_q  <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			state_q <= state_d;

			if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end

			if (state_q == S_IDLE) begin
				vld_s1 <= 1'b0;
				dcnt_q <= '0;
				if (cfg_acc) begin
					sz_q <= cfg_sz;
				end
			end else if (state_q == S_SCAN) begin
				vld_s1 <= 1'b1;
			end else if (state_q == S_DIV) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end else if (state_q == S_BASE) begin
				cap_q  <= cap_sat;
				base_q <= OFS_W'(PAGE_BYTES) - cap_prod[OFS_W-1:0];
			end

			// A finished result takes the output register as soon as it is free.
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cfg_acc) begin
					num_q <= NUM_W'(PAGE_BITS);
					den_q <= {cfg_sz, 3'b000} + DEN_W'(1);
					rem_q <= '0;
				end else if (in_acc) begin
					cmd_q  <= in_cmd;
					slot_q <= in_slot;
					// Resolved commands: range error, end marker or reserved code.
					res_status_q <= ((in_cmd == CMD_DELETE || in_cmd == CMD_QUERY)
					                 && !in_range) ? ST_RANGE : ST_OK;
					res_slot_q   <= (in_cmd == CMD_DELETE || in_cmd == CMD_QUERY)
					                ? RSLOT_W'(in_slot) : RSLOT_W'(cap_q);
					res_occ_q    <= 1'b0;
					res_want_q   <= 1'b0;
					if (in_cmd == CMD_NEXT) begin
						from_q <= in_next[IDX_W-1:0];
						word_q <= in_next[IDX_W-1:BIT_W];
					end else if (in_cmd == CMD_DELETE || in_cmd == CMD_QUERY) begin
						from_q <= in_slot[IDX_W-1:0];
						word_q <= in_slot[IDX_W-1:BIT_W];
					end else begin
						from_q <= '0;
						word_q <= '0;
					end
				end
			end
			S_DIV: begin
				num_q <= {num_q[NUM_W-2:0], rem_ge};
				rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			end
			S_SCAN: begin
				word_q  <= word_q + WADDR_W'(1);
				word_s1 <= word_q;
				if (vld_s1) begin
					if (scan_cmd) begin
						if (hit) begin
							res_status_q <= ST_OK;
							res_slot_q   <= RSLOT_W'({word_s1, cand_bit});
							res_occ_q    <= 1'b1;
							res_want_q   <= 1'b1;
						end else begin
							res_status_q <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_OK;
							res_slot_q   <= RSLOT_W'(cap_q);
						end
					end else begin
						res_slot_q   <= RSLOT_W'(slot_q);
						res_want_q   <= 1'b1;
						res_status_q <= slot_bit ? ST_OK : ST_EMPTY;
						res_occ_q    <= slot_bit && (cmd_q == CMD_QUERY);
					end
				end
			end
			S_MUL: begin
				prod_q <= slot_prod[OFS_W-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {6'b0, res_ofs, res_occ_q, res_slot_q};
					m_tuser_q <= {6'b0, res_status_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// The bitmap is written back only while a command evaluates a returned word.
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN && vld_s1))
		else $error("bitmap written outside a scan evaluation");

	// Capacity always stays a valid, nonzero slot count.
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (32'(cap_q) <= MAX_SLOTS))
		else $error("slot capacity out of range");

	// An occupied result always reports success and names a slot below capacity.
	a_occ_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[13]) |-> (m_tuser[1:0] == ST_OK && m_tdata[12:0] < cap_q))
		else $error("occupied result with bad status or slot");

	// A command is taken only when no result is pending inside the sequencer.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_SCAN || state_q == S_MUL))
		else $error("accepted command did not start");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_page_slot_bitmap_allocator.sv
// Self-checking testbench for the page slot bitmap allocator with its own occupancy model.
`timescale 1ns / 100ps

module tb_page_slot_bitmap_allocator
	import psba_pkg::*;
();

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 8;
	// Cycles with no transfer at all before the run is declared hung. The longest
	// quiet stretch in a correct run is a receiver hold-off plus a sender gap, a
	// capacity division and a full scan.
	localparam int WATCHDOG_LIMIT = 4000;
	// Quiet cycles after the last result before the register is rewritten.
	localparam int DRAIN_SETTLE = 4;
	localparam int TAIL_CYCLES  = 100;
	localparam int MAX_PRINTED  = 40;
	localparam int HOLD_CYCLES  = 400;

	// Command codes with no function; the block must answer them and change nothing.
	localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

	typedef enum logic [1:0] {
		PLAN_CMD,
		PLAN_CFG,
		PLAN_DRAIN
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t          kind;
		logic [CMD_W-1:0]    cmd;
		logic [SLOT_W-1:0]   slot;
		logic [TSZ_W-1:0]    tsz;
	} plan_entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RSLOT_W-1:0]  rslot;
		logic                occ;
		logic [OFS_W-1:0]    ofs;
	} slot_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TSZ_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;   // [11:0] slot
	logic [7:0]        s_tuser = '0;   // [2:0] cmd
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;        // [12:0] result_slot, [13] occupied, [25:14] byte_offset
	logic [7:0]        m_tuser;        // [1:0] status

	page_slot_bitmap_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Occupancy model of the page, advanced at each accepted command transfer.
	bit               slot_used [MAX_SLOTS];
	logic [TSZ_W-1:0] model_tsz;
	int               model_cap;

	plan_entry_t  cmd_plan [$];
	slot_result_t replies_due [$];

	int err_count    = 0;
	int results_seen = 0;
	int plan_cap;
	int plan_fill    = 0;

	function automatic int capacity_for(logic [TSZ_W-1:0] tsz);
		int sz;
		int c;
		sz = (tsz == 0) ? 1 : int'(tsz);
		c = PAGE_BITS / (sz * BITS_PER_BYTE + 1);
		if (c > MAX_SLOTS)
			c = MAX_SLOTS;
		return c;
	endfunction

	function automatic logic [OFS_W-1:0] record_offset(int s);
		int sz;
		sz = (model_tsz == 0) ? 1 : int'(model_tsz);
		return OFS_W'(PAGE_BYTES - model_cap * sz + s * sz);
	endfunction

	function automatic slot_result_t run_page_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot);
		slot_result_t r;
		int si;
		int i;
		bit hit;
		si = slot;
		hit = 1'b0;
		r.status = ST_OK;
		r.rslot = RSLOT_W'(model_cap);
		r.occ = 1'b0;
		r.ofs = '0;
		case (cmd)
			CMD_INSERT: begin
				r.status = ST_FULL;
				for (i = 0; i < model_cap && !hit; i++) begin
					if (!slot_used[i]) begin
						hit = 1'b1;
						slot_used[i] = 1'b1;
						r.status = ST_OK;
						r.rslot = RSLOT_W'(i);
						r.occ = 1'b1;
						r.ofs = record_offset(i);
					end
				end
			end
			CMD_DELETE, CMD_QUERY: begin
				r.rslot = RSLOT_W'(si);
				if (si >= model_cap) begin
					r.status = ST_RANGE;
				end else if (!slot_used[si]) begin
					r.status = ST_EMPTY;
					r.ofs = record_offset(si);
				end else begin
					r.ofs = record_offset(si);
					if (cmd == CMD_DELETE)
						slot_used[si] = 1'b0;
					else
						r.occ = 1'b1;
				end
			end
			CMD_FIRST, CMD_NEXT: begin
				// Bits above the current capacity stay stored but are never seen.
				for (i = (cmd == CMD_FIRST) ? 0 : si + 1; i < model_cap && !hit; i++) begin
					if (slot_used[i]) begin
						hit = 1'b1;
						r.rslot = RSLOT_W'(i);
						r.occ = 1'b1;
						r.ofs = record_offset(i);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int draw_idle(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic report_error(string msg);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Stimulus plan. Slot capacity and a rough fill level are tracked at plan
	// time so that most slot arguments land on slots that are likely in use.
	task automatic queue_cmd(logic [CMD_W-1:0] c, int s);
		plan_entry_t e;
		e.kind = PLAN_CMD;
		e.cmd = c;
		e.slot = SLOT_W'(s);
		e.tsz = '0;
		cmd_plan.push_back(e);
	endtask

	task automatic queue_cfg(int tsz);
		plan_entry_t e;
		e.kind = PLAN_CFG;
		e.cmd = CMD_INSERT;
		e.slot = '0;
		e.tsz = TSZ_W'(tsz);
		cmd_plan.push_back(e);
		plan_cap = capacity_for(TSZ_W'(tsz));
	endtask

	task automatic queue_drain();
		plan_entry_t e;
		e.kind = PLAN_DRAIN;
		e.cmd = CMD_INSERT;
		e.slot = '0;
		e.tsz = '0;
		cmd_plan.push_back(e);
	endtask

	function automatic int pick_slot();
		int hi;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(plan_cap - 1, plan_cap);
		hi = plan_fill + 2;
		if (hi > plan_cap - 1)
			hi = plan_cap - 1;
		return $urandom_range(0, hi);
	endfunction

	task automatic queue_random_cmd();
		int r;
		int s;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, (1 << SLOT_W) - 1);
		if (r < 40) begin
			queue_cmd(CMD_INSERT, s);
			plan_fill++;
		end else if (r < 60)
			queue_cmd(CMD_DELETE, pick_slot());
		else if (r < 72)
			queue_cmd(CMD_QUERY, pick_slot());
		else if (r < 80)
			queue_cmd(CMD_FIRST, s);
		else if (r < 92)
			queue_cmd(CMD_NEXT, pick_slot());
		else if (r < 96)
			queue_cmd(CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)), s);
		else
			queue_cmd(r[0] ? CMD_DELETE : CMD_QUERY, s);
	endtask

	task automatic queue_random_phase(int tsz, int count);
		queue_cfg(tsz);
		repeat (count) queue_random_cmd();
	endtask

	initial begin
		int c;
		model_tsz = TSZ_W'(TSZ_RST);
		model_cap = capacity_for(model_tsz);
		plan_cap = model_cap;

		// Directed part on the reset configuration: empty page, claims, frees,
		// scans from and past the end, out-of-range slots and unused codes.
		queue_cmd(CMD_FIRST, 0);
		queue_cmd(CMD_QUERY, 0);
		queue_cmd(CMD_DELETE, 0);
		repeat (3) queue_cmd(CMD_INSERT, (1 << SLOT_W) - 1);
		queue_cmd(CMD_QUERY, 1);
		queue_cmd(CMD_DELETE, 1);
		queue_cmd(CMD_DELETE, 1);
		queue_cmd(CMD_INSERT, 0);
		queue_cmd(CMD_NEXT, 0);
		queue_cmd(CMD_NEXT, (1 << SLOT_W) - 1);
		queue_cmd(CMD_NEXT, plan_cap - 1);
		queue_cmd(CMD_QUERY, (1 << SLOT_W) - 1);
		queue_cmd(CMD_DELETE, plan_cap);
		queue_cmd(CMD_QUERY, plan_cap - 1);
		for (c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
			queue_cmd(CMD_W'(c), (1 << SLOT_W) - 1);
		queue_cmd(CMD_FIRST, 0);

		// Largest tuple size leaves a single slot, already taken from before the
		// resize, so the page starts out full.
		queue_cfg((1 << TSZ_W) - 1);
		queue_cmd(CMD_INSERT, 0);
		queue_cmd(CMD_DELETE, 0);
		queue_cmd(CMD_INSERT, 0);
		queue_cmd(CMD_INSERT, 0);
		queue_cmd(CMD_QUERY, 0);
		queue_cmd(CMD_NEXT, 0);
		plan_fill = 3;

		// Random part. A zero size acts as one byte; small capacities fill up fast.
		queue_random_phase(0, 120);
		queue_random_phase(64, 180);
		queue_random_phase(512, 100);
		queue_random_phase(2000, 60);
		queue_random_phase(1, 120);
		queue_random_phase($urandom_range(1, 300), 80);
		queue_random_phase($urandom_range(1, 300), 80);
		queue_random_phase($urandom_range(1, (1 << TSZ_W) - 1), 80);
		queue_random_phase(TSZ_RST, 100);
		queue_drain();
		repeat (100) queue_random_cmd();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_plan.size() != 0 || s_tvalid || cfg_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Command and register driver. The model is advanced at each accepted
	// transfer; register writes and drains wait until no result is outstanding.
	int sender_gap    = 0;
	int settle_cycles = 0;
	bit sender_burst  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		plan_entry_t head;
		logic nx_s_valid;
		logic nx_cfg_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nx_s_valid = s_tvalid;
			nx_cfg_valid = cfg_valid;
			if (s_tvalid && s_tready) begin
				replies_due.push_back(run_page_cmd(s_tuser[CMD_W-1:0], s_tdata[SLOT_W-1:0]));
				nx_s_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				// Resizing keeps the stored bits; only capacity and offsets move.
				model_tsz = cfg_data;
				model_cap = capacity_for(cfg_data);
				nx_cfg_valid = 1'b0;
			end
			if (replies_due.size() == 0 && !nx_s_valid && !nx_cfg_valid)
				settle_cycles++;
			else
				settle_cycles = 0;

			if (!nx_s_valid && !nx_cfg_valid) begin
				if (sender_gap > 0) begin
					sender_gap--;
				end else if (cmd_plan.size() != 0) begin
					head = cmd_plan[0];
					case (head.kind)
						PLAN_CMD: begin
							void'(cmd_plan.pop_front());
							nx_s_valid = 1'b1;
							s_tdata <= 16'(head.slot);
							s_tuser <= 8'(head.cmd);
							if ($urandom_range(0, 39) == 0)
								sender_burst = !sender_burst;
							sender_gap = draw_idle(sender_burst);
						end
						PLAN_CFG: begin
							if (settle_cycles >= DRAIN_SETTLE) begin
								void'(cmd_plan.pop_front());
								nx_cfg_valid = 1'b1;
								cfg_data <= head.tsz;
							end
						end
						default: begin
							if (settle_cycles >= DRAIN_SETTLE)
								void'(cmd_plan.pop_front());
						end
					endcase
				end
			end
			s_tvalid <= nx_s_valid;
			cfg_valid <= nx_cfg_valid;
		end
	end

	// Result monitor and receiver. Twice in the run it holds off for a long
	// stretch so that the block backs up and stops taking commands.
	int recv_stall  = 0;
	int hold_cycles = 0;
	bit recv_burst  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		logic nx_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing outstanding",
						results_seen));
				end else begin
					want = replies_due.pop_front();
					if (m_tuser[STATUS_W-1:0] !== want.status)
						report_error($sformatf("result %0d status: got %0d, want %0d",
							results_seen, m_tuser[STATUS_W-1:0], want.status));
					if (m_tdata[RSLOT_W-1:0] !== want.rslot)
						report_error($sformatf("result %0d slot: got %0d, want %0d",
							results_seen, m_tdata[RSLOT_W-1:0], want.rslot));
					if (m_tdata[RSLOT_W] !== want.occ)
						report_error($sformatf("result %0d occupied: got %0d, want %0d",
							results_seen, m_tdata[RSLOT_W], want.occ));
					if (m_tdata[RSLOT_W+OFS_W:RSLOT_W+1] !== want.ofs)
						report_error($sformatf("result %0d byte offset: got %0d, want %0d",
							results_seen, m_tdata[RSLOT_W+OFS_W:RSLOT_W+1], want.ofs));
				end
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
				recv_stall = draw_idle(recv_burst);
				if (results_seen == 120 || results_seen == 650)
					hold_cycles = HOLD_CYCLES;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				nx_ready = 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				nx_ready = 1'b0;
			end else begin
				nx_ready = 1'b1;
			end
			m_tready <= nx_ready;
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] ERROR: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

FILE: page_slot_bitmap_allocator.f
hdl/psba_pkg.sv
hdl/psba_ram.sv
hdl/page_slot_bitmap_allocator.sv
sim/tb_page_slot_bitmap_allocator.sv
